FILE: hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  typedef logic signed [DATA_W-1:0] sample_t;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(4);

  // Result request from the sequencer to the output register
  typedef struct packed {
    logic    emit;
    sample_t value;
  } result_t;

endpackage

FILE: hw/rtl/sliding_window_maximum_top.sv
// Sliding window maximum: config register, deque sequencer, deque memory, output register.
//
// Usage:
//   The input channel (in_valid, in_stall, sample, restart) takes one signed
//   sample per request. restart empties the deque and the fill count before
//   the sample is taken. The output channel (out_valid, out_stall,
//   window_max) gives the maximum of the last window_len samples once that
//   many samples have arrived since reset or restart; earlier samples give
//   no result. window_len is written through cfg_write / cfg_data while the
//   block is idle; 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
//   A sample reads the front entry, drops expired front entries, then reads
//   and drops smaller back entries while older entries remain, and is then
//   appended; the single read port of the deque memory makes each of these
//   reads a separate step. Each entry is dropped at most once. At the
//   earliest, the result is loaded into the output register from the front
//   walk step that follows acceptance.
//   Reset empties the deque and sets window_len to 4; no clearing pass.
//   A stalled result is held; the next sample is taken meanwhile and waits
//   at its append step until the output register frees.
module sliding_window_maximum_top #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [swm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  swm_pkg::sample_t          sample,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output swm_pkg::sample_t          window_max
);

  import swm_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int EW = DATA_W + PW;

  logic [CFG_W-1:0] window_len;
  logic             out_free;
  result_t          res;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [EW-1:0]    mem_rd_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [EW-1:0]    mem_wr_data;

  // Hold the window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_write) begin
      window_len <= cfg_data;
    end
  end

  assign out_free = !out_valid || !out_stall;

  swm_seq #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .window_len  (window_len),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .restart     (restart),
    .out_free    (out_free),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  swm_mem #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Load a new result, drop it once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      window_max <= res.value;
    end
  end

endmodule

FILE: hw/rtl/swm_mem.sv
// Deque storage: one write port, one read port with registered read data.
module swm_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 39,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the new entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/swm_seq.sv
// Deque sequencer: front expiry walk, back pop walk and append over the deque memory.
module swm_seq #(
  parameter int WINDOW_MAX = 64,
  localparam int AW    = $clog2(WINDOW_MAX),
  localparam int CNT_W = $clog2(WINDOW_MAX + 1),
  localparam int PW    = $clog2(2 * WINDOW_MAX),
  localparam int EW    = swm_pkg::DATA_W + PW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [swm_pkg::CFG_W-1:0] window_len,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  swm_pkg::sample_t          sample,
  input  logic                      restart,
  input  logic                      out_free,
  output swm_pkg::result_t          res,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  input  logic [EW-1:0]             mem_rd_data,
  output logic                      mem_wr_en,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [EW-1:0]             mem_wr_data
);

  import swm_pkg::*;

  localparam int SW   = AW + 1;
  localparam int WIDE = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FRONT = 2'd1;
  localparam logic [1:0] S_BACK  = 2'd2;

  logic [1:0]       state, state_next;
  logic [AW-1:0]    front, front_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PW-1:0]    pos, pos_next;
  logic [CNT_W-1:0] fill, fill_next;
  sample_t          x, x_next;
  sample_t          front_val, front_val_next;

  logic [WIDE-1:0]  w_wide;
  logic [CNT_W-1:0] w;
  sample_t          rd_value;
  logic [PW-1:0]    rd_pos;
  logic [PW-1:0]    age;
  logic             finish;
  logic [CNT_W-1:0] base;

  // Wrap an offset from a slot around the circular buffer
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] start,
                                             input logic [CNT_W-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(start) + SW'(off);
    if (sum >= SW'(WINDOW_MAX)) begin
      sum = sum - SW'(WINDOW_MAX);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] start);
    logic [AW-1:0] r;
    if (start == AW'(WINDOW_MAX - 1)) begin
      r = '0;
    end else begin
      r = start + AW'(1);
    end
    return r;
  endfunction

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    w_wide = WIDE'(window_len);
    if (window_len == '0) begin
      w_wide = WIDE'(1);
    end else if (w_wide > WIDE'(WINDOW_MAX)) begin
      w_wide = WIDE'(WINDOW_MAX);
    end
    w = w_wide[CNT_W-1:0];
  end

  // Split the entry read back from memory and take its age
  assign rd_value = mem_rd_data[EW-1:PW];
  assign rd_pos   = mem_rd_data[PW-1:0];

  always_comb begin
    if (pos >= rd_pos) begin
      age = pos - rd_pos;
    end else begin
      age = PW'({1'b0, pos} + (PW+1)'(2 * WINDOW_MAX) - {1'b0, rd_pos});
    end
  end

  assign in_stall = (state != S_IDLE);

  // Step the deque walk
  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    pos_next       = pos;
    fill_next      = fill;
    x_next         = x;
    front_val_next = front_val;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = front;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = front;
    mem_wr_data    = {x, pos};
    res            = '0;
    finish         = 1'b0;
    base           = count;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          x_next    = sample;
          mem_rd_en = 1'b1;
          if (restart) begin
            front_next  = '0;
            count_next  = '0;
            pos_next    = '0;
            fill_next   = '0;
            mem_rd_addr = '0;
          end
          state_next = S_FRONT;
        end
      end
      S_FRONT: begin
        if (count != '0 && age >= PW'(w)) begin
          // Drop the expired front entry and look at the next one
          front_next  = slot_inc(front);
          count_next  = count - CNT_W'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_inc(front);
        end else if (count != '0) begin
          front_val_next = rd_value;
          mem_rd_en      = 1'b1;
          mem_rd_addr    = slot_add(front, count - CNT_W'(1));
          state_next     = S_BACK;
        end else begin
          finish = 1'b1;
          base   = '0;
        end
      end
      S_BACK: begin
        if (rd_value < x) begin
          if (count == CNT_W'(1)) begin
            finish = 1'b1;
            base   = '0;
          end else begin
            // Drop the smaller back entry and read the one before it
            count_next  = count - CNT_W'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = slot_add(front, count - CNT_W'(2));
          end
        end else begin
          finish = 1'b1;
          base   = count;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Append the sample and hand the front value to the output register
    if (finish && out_free) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = slot_add(front, base);
      count_next  = base + CNT_W'(1);
      if (pos == PW'(2 * WINDOW_MAX - 1)) begin
        pos_next = '0;
      end else begin
        pos_next = pos + PW'(1);
      end
      if (fill < CNT_W'(WINDOW_MAX)) begin
        fill_next = fill + CNT_W'(1);
      end
      res.emit   = (fill_next >= w);
      res.value  = (base == '0) ? x : front_val;
      state_next = S_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      pos   <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pos   <= pos_next;
      fill  <= fill_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x         <= x_next;
    front_val <= front_val_next;
  end

  a_no_full_append: assert property (@(posedge clk) disable iff (rst)
    (finish && out_free) |-> (base < CNT_W'(WINDOW_MAX)))
    else $error("append into a full deque");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_FRONT))
    else $error("accepted request did not start the front walk");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    res.emit |-> (out_free && mem_wr_en))
    else $error("result issued without room or without append");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && restart) |=> (fill == '0 && pos == '0 && count == '0))
    else $error("restart did not clear the deque");

endmodule

FILE: bench/tb.sv
// Testbench for the sliding window maximum block: directed and random streams checked on the fly.
module tb;
  import swm_pkg::*;

  localparam int DEPTH         = 64;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 135;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data  = WINDOW_LEN_RESET;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  sample_t          sample    = '0;
  logic             restart   = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sample_t          window_max;

  // Window model: monotonic deque of value and position pairs
  sample_t          dq_value [DEPTH];
  logic [6:0]       dq_pos   [DEPTH];
  logic [5:0]       dq_head  = '0;
  logic [6:0]       dq_len   = '0;
  logic [6:0]       pos_ctr  = '0;
  logic [6:0]       fill_ctr = '0;
  logic [CFG_W-1:0] win_len  = WINDOW_LEN_RESET;

  sample_t pending_max [$];
  sample_t want;
  int      errors  = 0;
  int      quiet   = 0;
  bit      idle_on = 1'b1;

  sliding_window_maximum_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_max (window_max)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit idle_now();
    return idle_on && ($urandom_range(0, 99) < 16);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Advance the window model by one accepted sample and queue its maximum
  function automatic void advance_window(input sample_t value, input logic clear);
    logic [6:0] span;
    logic [6:0] age;
    logic [5:0] tail;
    bit         done;
    span = (win_len == 0) ? 7'd1 : (win_len > DEPTH) ? 7'(DEPTH) : win_len;
    if (clear) begin
      dq_head  = '0;
      dq_len   = '0;
      fill_ctr = '0;
      pos_ctr  = '0;
    end
    // drop expired entries at the front
    done = 1'b0;
    while (dq_len > 0 && !done) begin
      age = pos_ctr - dq_pos[dq_head];
      if (age >= span) begin
        dq_head++;
        dq_len--;
      end else begin
        done = 1'b1;
      end
    end
    // drop strictly smaller entries at the back
    done = 1'b0;
    while (dq_len > 0 && !done) begin
      tail = dq_head + 6'(dq_len - 1);
      if (dq_value[tail] < value) dq_len--;
      else done = 1'b1;
    end
    if (dq_len >= DEPTH) begin
      dq_head++;
      dq_len--;
    end
    tail = dq_head + 6'(dq_len);
    dq_value[tail] = value;
    dq_pos[tail]   = pos_ctr;
    dq_len++;
    pos_ctr++;
    if (fill_ctr < DEPTH) fill_ctr++;
    if (fill_ctr >= span) pending_max.push_back(dq_value[dq_head]);
  endfunction

  // Hold one request until it is taken, with an optional gap before it
  task automatic send_sample(input sample_t value, input logic clear);
    if (idle_now()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
    in_valid <= 1'b1;
    sample   <= value;
    restart  <= clear;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_window(value, clear);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_max.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    win_len = len;
  endtask

  // Field extremes, equal values and the reset window length
  task automatic test_extremes();
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd3, 1'b0);
  endtask

  // Window of one, and zero acting as one
  task automatic test_short_windows();
    write_window(7'd1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    write_window(7'd0);
    send_sample(-32'sd7, 1'b0);
    send_sample(32'sd9, 1'b0);
  endtask

  // Length above the deque depth saturates
  task automatic test_saturated_window();
    write_window(7'h7f);
    send_sample(32'sd1, 1'b1);
    send_sample(32'sd2, 1'b0);
    send_sample(32'sd1, 1'b0);
  endtask

  // Shrink the window mid-stream, then restart
  task automatic test_window_shrink();
    write_window(7'd2);
    send_sample(-32'sd4, 1'b0);
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(-32'sd4, 1'b0);
    send_sample(-32'sd4, 1'b0);
  endtask

  // Random streams in runs of random, narrow-range, rising and falling ramp and extreme-value shapes
  task automatic test_random_stream();
    logic [CFG_W-1:0] lens [10];
    sample_t          value;
    sample_t          ramp;
    int               shape;
    int               run_left;
    int               restart_pct;
    lens     = '{7'd1, 7'd64, 7'd2, 7'h7f, 7'd0, 7'd5, 7'd33, 7'd64, 7'd3, 7'd17};
    ramp     = '0;
    shape    = 0;
    run_left = 0;
    for (int p = 0; p < 10; p++) begin
      restart_pct = (p == 1 || p == 7) ? 0 : 3;
      write_window((p == 9) ? CFG_W'($urandom_range(1, 127)) : lens[p]);
      idle_on = (p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (run_left == 0) begin
          shape    = $urandom_range(0, 4);
          run_left = $urandom_range(1, 70);
          ramp     = $urandom;
        end
        run_left--;
        case (shape)
          0: value = $urandom;
          1: value = int'($urandom_range(0, 8)) - 4;
          2: begin
            ramp  = ramp + $urandom_range(0, 3);
            value = ramp;
          end
          3: begin
            ramp  = ramp - $urandom_range(0, 3);
            value = ramp;
          end
          default: value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
        send_sample(value, $urandom_range(0, 99) < restart_pct);
      end
    end
    idle_on = 1'b1;
  endtask

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= idle_now();
  end

  // Compare each taken result with the oldest expected maximum
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_max.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", window_max));
      end else begin
        want = pending_max.pop_front();
        if (window_max !== want)
          report_mismatch($sformatf("window_max %0d, expected %0d", window_max, want));
      end
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_short_windows();
    test_saturated_window();
    test_window_shrink();
    test_random_stream();
    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
